// ===== src/afrp_pkg.sv =====
// ----------------------------------------------------------------------------
// afrp_pkg
// Shared types and constants for the API frame receive parser.
// ----------------------------------------------------------------------------
`default_nettype none

package afrp_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned EventW = 3;

  // Framing bytes
  localparam logic [ByteW-1:0] DelimByte = 8'h7E;
  localparam logic [ByteW-1:0] IdRx16    = 8'h81;
  localparam logic [ByteW-1:0] IdTxStat  = 8'h89;

  // Length overhead of a receive frame: identifier plus source address
  localparam logic [WordW-1:0] RxOverhead = 16'd3;

  // Event codes reported with each word
  typedef enum logic [EventW-1:0] {
    EvHeader   = 3'd0,
    EvBody     = 3'd1,
    EvRxDone   = 3'd2,
    EvStatDone = 3'd3,
    EvDesync   = 3'd4,
    EvUnknown  = 3'd5
  } event_e;

  // Parser phase
  typedef enum logic [3:0] {
    PhHunt     = 4'd0,
    PhLenMsb   = 4'd1,
    PhLenLsb   = 4'd2,
    PhApiId    = 4'd3,
    PhSrcMsb   = 4'd4,
    PhSrcLsb   = 4'd5,
    PhBody     = 4'd6,
    PhRxCsum   = 4'd7,
    PhFrameId  = 4'd8,
    PhStatus   = 4'd9,
    PhStatCsum = 4'd10
  } phase_e;

  // One result word
  typedef struct packed {
    event_e           event_res;
    logic [ByteW-1:0] body_byte;
    logic [WordW-1:0] body_index;
    logic [WordW-1:0] source_address;
    logic [WordW-1:0] frame_length;
    logic [ByteW-1:0] status_frame_id;
    logic [ByteW-1:0] status_code;
  } afrp_res_t;

endpackage

`default_nettype wire

// ===== src/afrp_if.sv =====
// ----------------------------------------------------------------------------
// afrp_in_if / afrp_out_if
// Valid/ready channels for received bytes and parser result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface afrp_in_if import afrp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afrp_out_if import afrp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [EventW-1:0] event_res;
  logic [ByteW-1:0] body_byte;
  logic [WordW-1:0] body_index;
  logic [WordW-1:0] source_address;
  logic [WordW-1:0] frame_length;
  logic [ByteW-1:0] status_frame_id;
  logic [ByteW-1:0] status_code;

  modport source (output valid, output event_res, output body_byte, output body_index,
                  output source_address, output frame_length, output status_frame_id,
                  output status_code, input ready);
  modport sink   (input valid, input event_res, input body_byte, input body_index,
                  input source_address, input frame_length, input status_frame_id,
                  input status_code, output ready);
endinterface

`default_nettype wire

// ===== src/afrp_parse.sv =====
// ----------------------------------------------------------------------------
// afrp_parse
// Frame state machine: consumes one byte per step and forms the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module afrp_parse import afrp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  output afrp_res_t        res_o
);

  phase_e           phase_q, phase_d;
  logic [WordW-1:0] length_q, length_d;
  logic [WordW-1:0] source_q, source_d;
  logic [WordW-1:0] count_q, count_d;
  logic [ByteW-1:0] fid_q, fid_d;
  logic [ByteW-1:0] status_q, status_d;

  logic [WordW-1:0] count_inc;
  logic             body_more;

  // Body continues while length >= 3 and the next count stays under length - 3
  assign count_inc = count_q + 16'd1;
  assign body_more = (length_q >= RxOverhead) && (count_inc < (length_q - RxOverhead));

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PhLenMsb:   phase_d = PhLenLsb;
      PhLenLsb:   phase_d = PhApiId;
      PhApiId: begin
        if (byte_i == IdRx16) begin
          phase_d = PhSrcMsb;
        end else if (byte_i == IdTxStat) begin
          phase_d = PhFrameId;
        end else begin
          phase_d = PhHunt;
        end
      end
      PhSrcMsb:   phase_d = PhSrcLsb;
      PhSrcLsb:   phase_d = PhBody;
      PhBody:     phase_d = body_more ? PhBody : PhRxCsum;
      PhRxCsum:   phase_d = PhHunt;
      PhFrameId:  phase_d = PhStatus;
      PhStatus:   phase_d = PhStatCsum;
      PhStatCsum: phase_d = PhHunt;
      default:    phase_d = (byte_i == DelimByte) ? PhLenMsb : PhHunt;
    endcase
  end

  // Held fields and result word
  always_comb begin
    length_d = length_q;
    source_d = source_q;
    count_d  = count_q;
    fid_d    = fid_q;
    status_d = status_q;
    res_o.event_res  = EvHeader;
    res_o.body_byte  = '0;
    res_o.body_index = '0;
    unique case (phase_q)
      PhLenMsb:   length_d = {byte_i, 8'h00};
      PhLenLsb:   length_d = {length_q[WordW-1:ByteW], byte_i};
      PhApiId: begin
        if (byte_i != IdRx16 && byte_i != IdTxStat) begin
          res_o.event_res = EvUnknown;
        end
      end
      PhSrcMsb: begin
        source_d = {byte_i, 8'h00};
        count_d  = '0;
      end
      PhSrcLsb:   source_d = {source_q[WordW-1:ByteW], byte_i};
      PhBody, PhRxCsum: begin
        res_o.event_res  = (phase_q == PhBody) ? EvBody : EvRxDone;
        res_o.body_byte  = byte_i;
        res_o.body_index = count_q;
        count_d          = count_inc;
      end
      PhFrameId:  fid_d = byte_i;
      PhStatus:   status_d = byte_i;
      PhStatCsum: res_o.event_res = EvStatDone;
      default: begin
        if (byte_i != DelimByte) begin
          res_o.event_res = EvDesync;
        end
      end
    endcase
    res_o.source_address  = source_d;
    res_o.frame_length    = length_d;
    res_o.status_frame_id = fid_d;
    res_o.status_code     = status_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      length_q <= '0;
      source_q <= '0;
      count_q  <= '0;
      fid_q    <= '0;
      status_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      length_q <= length_d;
      source_q <= source_d;
      count_q  <= count_d;
      fid_q    <= fid_d;
      status_q <= status_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/api_frame_receive_parser_unit.sv =====
// Byte accept to result word valid: input register, then result register.
// Throughput: 1 byte per cycle unless res_o.ready stalls; the phase update is a few byte
//   compares and one 16-bit increment/compare, all combinational between the two registers.
// Reset (rst_ni low, async): parser hunts for the start delimiter, all held
//   fields read zero, both pipeline registers empty.
// ----------------------------------------------------------------------------
// api_frame_receive_parser_unit
// Byte-stream deframer for serial-radio API frames; one result word per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module api_frame_receive_parser_unit import afrp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  afrp_in_if.sink      rx_i,
  afrp_out_if.source   res_o
);

  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_vld_q;
  afrp_res_t        out_res_q;
  afrp_res_t        step_res;
  logic             step;

  // Move the held byte forward when the result register is free or draining
  assign step       = in_vld_q && (!out_vld_q || res_o.ready);
  assign rx_i.ready = !in_vld_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  afrp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .res_o  (step_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= step_res;
    end
  end

  assign res_o.valid           = out_vld_q;
  assign res_o.event_res       = out_res_q.event_res;
  assign res_o.body_byte       = out_res_q.body_byte;
  assign res_o.body_index      = out_res_q.body_index;
  assign res_o.source_address  = out_res_q.source_address;
  assign res_o.frame_length    = out_res_q.frame_length;
  assign res_o.status_frame_id = out_res_q.status_frame_id;
  assign res_o.status_code     = out_res_q.status_code;

endmodule

`default_nettype wire

// ===== tb/sv/tb_api_frame_receive_parser_unit.sv =====
// ----------------------------------------------------------------------------
// tb_api_frame_receive_parser_unit
// Self-checking bench for the API frame deframer. Serial bytes are queued as
// whole receive/status frames, unknown identifiers, cut-off frames and line
// noise. They are driven with random idle bursts on both channels, and every
// result word is checked against a local model of the deframer.
// ----------------------------------------------------------------------------
module tb_api_frame_receive_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import afrp_pkg::*;

  localparam int RandomBytes = 950;
  localparam int TailBytes   = 150;    // no idling once this few bytes remain
  localparam int HoldAt      = 250;    // long result stall starts here
  localparam int HoldCycles  = 400;
  localparam int DrainAt     = 600;    // sender waits for all results here
  localparam int CycleLimit  = 200000;
  localparam int MaxReports  = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  afrp_in_if  rx_if ();
  afrp_out_if res_if ();

  api_frame_receive_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Serial bytes waiting to be sent, and the result words they must produce
  logic [ByteW-1:0] rx_pending[$];
  afrp_res_t        words_due[$];

  int bytes_offered = 0;
  int bytes_taken   = 0;
  int total_bytes   = 0;
  int mismatches    = 0;
  int cycle_cnt     = 0;

  // Deframer state mirrored by the bench
  phase_e           parse_ph;
  logic [WordW-1:0] len_q;
  logic [WordW-1:0] src_q;
  logic [WordW-1:0] body_cnt_q;
  logic [ByteW-1:0] fid_q;
  logic [ByteW-1:0] stat_q;

  // Sender/receiver pacing
  int   src_gap = 0;
  int   snk_gap = 0;
  int   hold_left = 0;
  logic src_calm = 1'b0;
  logic snk_calm = 1'b0;
  logic hold_done = 1'b0;

  // Work out the result word for one accepted byte
  task automatic deframe_byte(input logic [ByteW-1:0] b);
    afrp_res_t        w;
    logic [WordW-1:0] nxt;
    w = '0;
    w.event_res = EvHeader;
    case (parse_ph)
      PhLenMsb: begin
        len_q    = {b, 8'h00};
        parse_ph = PhLenLsb;
      end
      PhLenLsb: begin
        len_q[7:0] = b;
        parse_ph   = PhApiId;
      end
      PhApiId: begin
        if (b == IdRx16) begin
          parse_ph = PhSrcMsb;
        end else if (b == IdTxStat) begin
          parse_ph = PhFrameId;
        end else begin
          w.event_res = EvUnknown;
          parse_ph    = PhHunt;
        end
      end
      PhSrcMsb: begin
        src_q      = {b, 8'h00};
        body_cnt_q = '0;
        parse_ph   = PhSrcLsb;
      end
      PhSrcLsb: begin
        src_q[7:0] = b;
        parse_ph   = PhBody;
      end
      PhBody: begin
        // body always takes one byte, even for a short length
        w.event_res  = EvBody;
        w.body_byte  = b;
        w.body_index = body_cnt_q;
        nxt          = body_cnt_q + 16'd1;
        body_cnt_q   = nxt;
        if (!(len_q >= RxOverhead && nxt < len_q - RxOverhead)) parse_ph = PhRxCsum;
      end
      PhRxCsum: begin
        // checksum passes through unchecked
        w.event_res  = EvRxDone;
        w.body_byte  = b;
        w.body_index = body_cnt_q;
        body_cnt_q   = body_cnt_q + 16'd1;
        parse_ph     = PhHunt;
      end
      PhFrameId: begin
        fid_q    = b;
        parse_ph = PhStatus;
      end
      PhStatus: begin
        stat_q   = b;
        parse_ph = PhStatCsum;
      end
      PhStatCsum: begin
        w.event_res = EvStatDone;
        parse_ph    = PhHunt;
      end
      default: begin
        if (b == DelimByte) begin
          parse_ph = PhLenMsb;
        end else begin
          w.event_res = EvDesync;
          parse_ph    = PhHunt;
        end
      end
    endcase
    w.source_address  = src_q;
    w.frame_length    = len_q;
    w.status_frame_id = fid_q;
    w.status_code     = stat_q;
    words_due.push_back(w);
  endtask

  // Compare one result word with the oldest one due
  task automatic check_word();
    afrp_res_t want;
    logic      bad;
    if (words_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: result word with none due: ev %0d byte %02h idx %04h", $realtime,
                 res_if.event_res, res_if.body_byte, res_if.body_index);
    end else begin
      want = words_due.pop_front();
      bad = (res_if.event_res !== want.event_res) || (res_if.body_byte !== want.body_byte) ||
            (res_if.body_index !== want.body_index) ||
            (res_if.source_address !== want.source_address) ||
            (res_if.frame_length !== want.frame_length) ||
            (res_if.status_frame_id !== want.status_frame_id) ||
            (res_if.status_code !== want.status_code);
      if (bad) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("%0t: mismatch, expected ev %0d byte %02h idx %04h src %04h len %04h fid %02h st %02h",
                   $realtime, want.event_res, want.body_byte, want.body_index,
                   want.source_address, want.frame_length, want.status_frame_id,
                   want.status_code);
          $display("%0t:           got      ev %0d byte %02h idx %04h src %04h len %04h fid %02h st %02h",
                   $realtime, res_if.event_res, res_if.body_byte, res_if.body_index,
                   res_if.source_address, res_if.frame_length, res_if.status_frame_id,
                   res_if.status_code);
        end
      end
    end
  endtask

  // Frame builders
  task automatic queue_rx_frame(input logic [WordW-1:0] len, input logic [WordW-1:0] src);
    int nbody;
    nbody = (len > 16'd4) ? int'(len) - 3 : 1;
    rx_pending.push_back(DelimByte);
    rx_pending.push_back(len[15:8]);
    rx_pending.push_back(len[7:0]);
    rx_pending.push_back(IdRx16);
    rx_pending.push_back(src[15:8]);
    rx_pending.push_back(src[7:0]);
    repeat (nbody) rx_pending.push_back(ByteW'($urandom));
    rx_pending.push_back(ByteW'($urandom));
  endtask

  task automatic queue_status_frame(input logic [WordW-1:0] len, input logic [ByteW-1:0] fid,
                                    input logic [ByteW-1:0] st);
    rx_pending.push_back(DelimByte);
    rx_pending.push_back(len[15:8]);
    rx_pending.push_back(len[7:0]);
    rx_pending.push_back(IdTxStat);
    rx_pending.push_back(fid);
    rx_pending.push_back(st);
    rx_pending.push_back(ByteW'($urandom));
  endtask

  task automatic queue_unknown_frame(input logic [WordW-1:0] len, input logic [ByteW-1:0] id);
    rx_pending.push_back(DelimByte);
    rx_pending.push_back(len[15:8]);
    rx_pending.push_back(len[7:0]);
    rx_pending.push_back(id);
  endtask

  // Input side: accept bytes into the model, check result words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        deframe_byte(rx_if.rx_byte);
        bytes_taken++;
      end
      if (res_if.valid && res_if.ready) check_word();
    end
  end

  // Byte driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_if.valid && bytes_taken < bytes_offered) begin
        // byte still waiting for ready
      end else if (rx_pending.size() == 0) begin
        rx_if.valid <= 1'b0;
      end else if (bytes_offered == DrainAt && words_due.size() != 0) begin
        rx_if.valid <= 1'b0;
      end else if (src_gap > 0) begin
        src_gap     <= src_gap - 1;
        rx_if.valid <= 1'b0;
      end else if (!src_calm && rx_pending.size() > TailBytes && $urandom_range(0, 5) == 0) begin
        src_gap     <= $urandom_range(0, 10);
        rx_if.valid <= 1'b0;
      end else begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= rx_pending.pop_front();
        bytes_offered <= bytes_offered + 1;
        if ($urandom_range(0, 49) == 0) src_calm <= !src_calm;
      end
    end
  end

  // Long result stall, counted on its own
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && bytes_taken >= HoldAt) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end
    end
  end

  // Result ready driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap      <= snk_gap - 1;
        res_if.ready <= 1'b0;
      end else if (!snk_calm && rx_pending.size() > TailBytes && $urandom_range(0, 5) == 0) begin
        snk_gap      <= $urandom_range(0, 10);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 49) == 0) snk_calm <= !snk_calm;
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int               pick;
    int               nb;
    logic [WordW-1:0] len;
    logic [ByteW-1:0] id;
    logic [ByteW-1:0] nz;

    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    parse_ph      = PhHunt;
    len_q         = '0;
    src_q         = '0;
    body_cnt_q    = '0;
    fid_q         = '0;
    stat_q        = '0;

    // Directed: noise extremes, short receive frame, status, unknown id, normal frame
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hFF);
    queue_rx_frame(16'h0000, 16'hFFFF);
    queue_status_frame(16'hFFFF, 8'h00, 8'hFF);
    queue_unknown_frame(16'h0004, 8'h00);
    queue_rx_frame(16'h0005, 16'h0000);

    // Random: mostly well-formed frames, some cut-off frames and noise
    while (rx_pending.size() < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = ($urandom_range(0, 19) == 0) ? WordW'($urandom_range(25, 120))
                                           : WordW'($urandom_range(0, 24));
        queue_rx_frame(len, WordW'($urandom));
      end else if (pick < 70) begin
        queue_status_frame(WordW'($urandom), ByteW'($urandom), ByteW'($urandom));
      end else if (pick < 78) begin
        id = ByteW'($urandom);
        if (id == IdRx16 || id == IdTxStat) id = id ^ 8'h01;
        queue_unknown_frame(WordW'($urandom), id);
      end else if (pick < 88) begin
        // cut-off header, then zeros that end as an unknown id and resync
        rx_pending.push_back(DelimByte);
        repeat ($urandom_range(0, 2)) rx_pending.push_back(ByteW'($urandom));
        repeat (3) rx_pending.push_back(8'h00);
      end else begin
        nb = $urandom_range(1, 5);
        repeat (nb) begin
          nz = ByteW'($urandom);
          if (nz == DelimByte) nz = 8'h7F;
          rx_pending.push_back(nz);
        end
      end
    end
    total_bytes = rx_pending.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken < total_bytes) @(posedge clk_i);
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== api_frame_receive_parser_unit.f =====
src/afrp_pkg.sv
src/afrp_if.sv
src/afrp_parse.sv
src/api_frame_receive_parser_unit.sv
tb/sv/tb_api_frame_receive_parser_unit.sv
